/* rtl/sctp_chk_pkg.sv */
// Shared types, constants and the CRC-32C byte update for the SCTP checksum checker.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none

package sctp_chk_pkg;

   // Largest packet size the byte position counts to before it saturates.
   localparam int MAX_PACKET_BYTES = 2048;

   // Position counter holds 0 .. MAX_PACKET_BYTES.
   localparam int POS_W  = $clog2(MAX_PACKET_BYTES + 1);
   localparam int LEN_W  = 12;
   localparam int WIDE_W = (POS_W > LEN_W) ? POS_W : LEN_W;

   localparam logic [31:0] CRC_POLY     = 32'h82F6_3B78;
   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

   // Checksum field occupies bytes SUM_FIRST .. SUM_END-1.
   localparam logic [POS_W-1:0] SUM_FIRST = POS_W'(8);
   localparam logic [POS_W-1:0] SUM_END   = POS_W'(12);
   localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_PACKET_BYTES);

   // Lane codes for the little-endian capture of the wire checksum.
   localparam logic [1:0] LANE_B0 = 2'd0;
   localparam logic [1:0] LANE_B1 = 2'd1;
   localparam logic [1:0] LANE_B2 = 2'd2;
   localparam logic [1:0] LANE_B3 = 2'd3;

   localparam int RSP_DATA_W = 80;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } step_type;

   typedef struct packed {
      logic [LEN_W-1:0] packet_length;
      logic             too_short;
      logic             checksum_match;
      logic [31:0]      received_checksum;
      logic [31:0]      computed_checksum;
   } result_type;

   // Reflected CRC-32C, one byte: eight shift/xor steps.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/sctp_chk_accum.sv */
// Per-packet accumulator: running CRC-32C, byte position and wire checksum capture.
// Uses sctp_chk_pkg (types, constants, crc_byte).
`default_nettype none

module sctp_chk_accum (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step_en,
   input  wire sctp_chk_pkg::step_type   step,
   output      sctp_chk_pkg::result_type result
);

   logic [31:0]                    crc_ff, crc_in;
   logic [sctp_chk_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [31:0]                    cap_ff, cap_in;

   logic                           in_field;
   logic [31:0]                    crc_next;
   logic [31:0]                    cap_next;
   logic [sctp_chk_pkg::POS_W-1:0] len_next;
   logic [sctp_chk_pkg::WIDE_W-1:0] len_wide;

   always_comb begin
      in_field = (pos_ff >= sctp_chk_pkg::SUM_FIRST) && (pos_ff < sctp_chk_pkg::SUM_END);

      // checksum field bytes are hashed as zero
      crc_next = sctp_chk_pkg::crc_byte(crc_ff, in_field ? 8'd0 : step.data_byte);

      cap_next = cap_ff;
      if (in_field) begin
         // bytes 8..11 map onto pos[1:0] = 0..3
         case (pos_ff[1:0])
            sctp_chk_pkg::LANE_B0: cap_next[7:0]   = step.data_byte;
            sctp_chk_pkg::LANE_B1: cap_next[15:8]  = step.data_byte;
            sctp_chk_pkg::LANE_B2: cap_next[23:16] = step.data_byte;
            sctp_chk_pkg::LANE_B3: cap_next[31:24] = step.data_byte;
            default:               cap_next = cap_ff;
         endcase
      end

      len_next = (pos_ff == sctp_chk_pkg::POS_MAX) ? pos_ff :
                 pos_ff + sctp_chk_pkg::POS_W'(1);
      len_wide = sctp_chk_pkg::WIDE_W'(len_next);

      result.computed_checksum = crc_next ^ sctp_chk_pkg::CRC_ALL_ONES;
      result.received_checksum = cap_next;
      result.too_short         = len_next < sctp_chk_pkg::SUM_END;
      result.checksum_match    = !result.too_short &&
                                 (cap_next == result.computed_checksum);
      result.packet_length     = len_wide[sctp_chk_pkg::LEN_W-1:0];

      crc_in = crc_ff;
      pos_in = pos_ff;
      cap_in = cap_ff;
      if (step_en) begin
         if (step.last_byte) begin
            crc_in = sctp_chk_pkg::CRC_ALL_ONES;
            pos_in = '0;
            cap_in = '0;
         end else begin
            crc_in = crc_next;
            pos_in = len_next;
            cap_in = cap_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= sctp_chk_pkg::CRC_ALL_ONES;
         pos_ff <= '0;
         cap_ff <= '0;
      end else begin
         crc_ff <= crc_in;
         pos_ff <= pos_in;
         cap_ff <= cap_in;
      end
   end

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= sctp_chk_pkg::POS_MAX)
      else $error("byte position beyond saturation limit");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step_en && step.last_byte |=>
         pos_ff == '0 && cap_ff == '0 && crc_ff == sctp_chk_pkg::CRC_ALL_ONES)
      else $error("state not cleared after final byte");

   a_pos_counts: assert property (@(posedge clock) disable iff (reset)
      step_en && !step.last_byte && pos_ff != sctp_chk_pkg::POS_MAX |=>
         pos_ff == $past(pos_ff) + sctp_chk_pkg::POS_W'(1))
      else $error("byte position did not advance");

endmodule

`default_nettype wire

/* rtl/sctp_chk_rsp.sv */
// Result register for the SCTP checksum checker; packs a result into rsp_tdata.
// Uses sctp_chk_pkg (result_type, RSP_DATA_W).
`default_nettype none

module sctp_chk_rsp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 load,
   input  wire sctp_chk_pkg::result_type              load_data,
   output      logic                                 slot_free,
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output      logic [sctp_chk_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic                     vld_ff, vld_in;
   sctp_chk_pkg::result_type res_ff, res_in;

   always_comb begin
      slot_free = !vld_ff || rsp_tready;
      vld_in    = load ? 1'b1 : (vld_ff && !rsp_tready);
      res_in    = load ? load_data : res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {2'b00, res_ff.packet_length, res_ff.too_short,
                        res_ff.checksum_match, res_ff.received_checksum,
                        res_ff.computed_checksum};

endmodule

`default_nettype wire

/* rtl/sctp_packet_checksum_check.sv */
// SCTP packet checksum checker. One packet byte enters per req transaction, in wire
// order, with req_tlast on the final byte. The block runs a reflected CRC-32C
// (poly 0x82F63B78, preset and final xor all ones) over the packet with bytes 8..11
// hashed as zero, and captures those four bytes little-endian as the wire checksum.
// The final byte of a packet produces exactly one rsp transaction carrying the
// computed checksum (its low byte belongs in packet byte 8), the wire checksum,
// a match flag, a too-short flag (packet under 12 bytes; match is then 0) and the
// packet length, saturated at sctp_chk_pkg::MAX_PACKET_BYTES. Other bytes produce
// no result. Throughput is one byte per clock, except while a final byte waits: the
// byte sits in an input register, a single byte-wide CRC update runs between it and
// the per-packet state, and the result lands in an output register, which loads as
// the final byte leaves the input register and drives rsp_tvalid. Only a final byte
// waits on a full output register; ordinary bytes keep flowing while a result is
// held for the consumer.
// Depends on sctp_chk_pkg, sctp_chk_accum and sctp_chk_rsp.
`default_nettype none

module sctp_packet_checksum_check (
   input  wire logic         clock,
   input  wire logic         reset,
   // request: one packet byte per transaction
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] data_byte
   input  wire logic         req_tlast,   // last_byte
   // response: one per packet
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic [79:0]  rsp_tdata    // [31:0] computed_checksum,
                                          // [63:32] received_checksum,
                                          // [64] checksum_match, [65] too_short,
                                          // [77:66] packet_length, [79:78] zero
);

   // input register
   logic                   in_vld_ff, in_vld_in;
   sctp_chk_pkg::step_type in_step_ff, in_step_in;

   logic                     advance;
   logic                     slot_free;
   logic                     load;
   sctp_chk_pkg::result_type result;

   always_comb begin
      // a final byte needs a free output slot; other bytes always move on
      advance    = in_vld_ff && (!in_step_ff.last_byte || slot_free);
      load       = advance && in_step_ff.last_byte;
      req_tready = !in_vld_ff || advance;

      in_vld_in  = req_tready ? req_tvalid : in_vld_ff;
      in_step_in = in_step_ff;
      if (req_tready && req_tvalid) begin
         in_step_in.data_byte = req_tdata;
         in_step_in.last_byte = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_step_ff <= in_step_in;
   end

   sctp_chk_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .step    (in_step_ff),
      .result  (result)
   );

   sctp_chk_rsp u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_data  (result),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // never overwrite a result the consumer has not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(load && rsp_tvalid && !rsp_tready))
      else $error("result register overwritten while held");

   // a stalled result stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // only a final byte can hold off the request side
   a_req_flow: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff || !in_step_ff.last_byte |-> req_tready)
      else $error("req_tready low without a waiting final byte");

endmodule

`default_nettype wire
